// ----- src/pdtt_pkg.sv -----
// ----------------------------------------------------------------------------
// pdtt_pkg
// Shared types and constants of the pulse duration tuning table.
// ----------------------------------------------------------------------------
package pdtt_pkg;

    localparam int BUCKETS = 16;

    typedef enum logic [1:0] {
        OP_DECIDE = 2'd0,
        OP_RECORD = 2'd1,
        OP_WRITE  = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    localparam logic [2:0] REG_WIDTH    = 3'd0;
    localparam logic [2:0] REG_FRACTION = 3'd1;
    localparam logic [2:0] REG_GAIN_UND = 3'd2;
    localparam logic [2:0] REG_GAIN_OVR = 3'd3;
    localparam logic [2:0] REG_FLOOR    = 3'd4;
    localparam logic [2:0] REG_CEILING  = 3'd5;
    localparam logic [2:0] REG_REJ_LOW  = 3'd6;
    localparam logic [2:0] REG_REJ_HIGH = 3'd7;

    // adjustment divisor 100 * 65536 = 2^18 * 25: shift by 18, then divide by 25
    localparam logic [22:0] ADJ_HALF  = 23'd3276800;
    // ceil(2^35 / 25), exact for shifted values below 2^30
    localparam logic [30:0] ADJ_RECIP = 31'd1374389535;
    // 25 * 2^25: quotients at or above 2^25 clamp the same way
    localparam logic [34:0] ADJ_SAT_Y = 35'd838860800;

    // controller -> datapath commands
    typedef struct packed {
        logic load;      // capture the input beat
        logic div_step;  // one restoring divide step
        logic mul_aim;   // aim product stage, table read
        logic err_calc;  // aim error, magnitude and gain select
        logic mul_gain;  // gain times error magnitude
        logic adj_recip; // scale by reciprocal of the divisor
        logic commit;    // write table, form result
    } t_cmd;

    typedef struct packed {
        logic rejected;
    } t_sts;

endpackage

// ----- src/pulse_duration_tuning_table.sv -----
// ----------------------------------------------------------------------------
// pulse_duration_tuning_table
// Per-bucket dosing pulse durations: decide, record, write and read entries.
// ----------------------------------------------------------------------------
// One item at a time. A decide, write or read beat, and a record beat that is
// rejected, runs the 17-step bucket divider and the aim stage before its
// result is loaded; an accepted record adds the error, gain product and
// reciprocal scaling stages. The input is ready again the cycle after the
// result is loaded; a result that waits on the output holds the input off.
module pulse_duration_tuning_table
    import pdtt_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_index,
    input  logic [23:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // op[1:0]
    input  logic [1:0]   s_axis_tuser,
    // gap[17:0], increment[35:18], entry_index[39:36],
    // entry_duration[63:40], entry_count[95:64]
    input  logic [95:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // bucket[3:0], target_wt[21:4], fire[22], pulse_ms[38:23], status[39],
    // read_duration[63:40], read_count[95:64]
    output logic [95:0]  m_axis_tdata
);

    t_cmd c_cmd;
    t_sts c_sts;
    logic r_ovalid;
    logic c_free;
    assign c_free = !r_ovalid || m_axis_tready;

    pdtt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_op       (t_op'(s_axis_tuser)),
        .i_sts      (c_sts),
        .i_out_free (c_free),
        .o_in_ready (s_axis_tready),
        .o_cmd      (c_cmd)
    );

    pdtt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (c_cmd),
        .i_op        (t_op'(s_axis_tuser)),
        .i_gap       (s_axis_tdata[17:0]),
        .i_inc       (s_axis_tdata[35:18]),
        .i_idx       (s_axis_tdata[39:36]),
        .i_edur      (s_axis_tdata[63:40]),
        .i_ecnt      (s_axis_tdata[95:64]),
        .o_sts       (c_sts),
        .o_bucket    (m_axis_tdata[3:0]),
        .o_aim       (m_axis_tdata[21:4]),
        .o_fire      (m_axis_tdata[22]),
        .o_pulse_ms  (m_axis_tdata[38:23]),
        .o_status    (m_axis_tdata[39]),
        .o_rd_dur    (m_axis_tdata[63:40]),
        .o_rd_cnt    (m_axis_tdata[95:64])
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (c_cmd.commit) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_ovalid;

endmodule

// ----- src/pdtt_ctrl.sv -----
// ----------------------------------------------------------------------------
// pdtt_ctrl
// Sequencer: bucket divide, aim product, error, gain product, scaling.
// ----------------------------------------------------------------------------
module pdtt_ctrl
    import pdtt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_op  i_op,
    input  t_sts i_sts,
    input  logic i_out_free,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_AIM, S_ERR, S_MUL, S_ADJ, S_DONE
    } t_state;

    t_state      r_state;
    t_op         r_op;
    logic [5:0]  r_cnt;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = (r_state == S_IDLE) && i_in_valid;
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.mul_aim   = (r_state == S_AIM);
        o_cmd.err_calc  = (r_state == S_ERR);
        o_cmd.mul_gain  = (r_state == S_MUL);
        o_cmd.adj_recip = (r_state == S_ADJ);
        o_cmd.commit    = (r_state == S_DONE) && i_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_DECIDE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_op;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd16) begin
                        r_state <= S_AIM;
                    end
                end
                S_AIM: begin
                    r_cnt   <= '0;
                    r_state <= (r_op == OP_RECORD && !i_sts.rejected) ? S_ERR : S_DONE;
                end
                S_ERR: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_state <= S_ADJ;
                end
                S_ADJ: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- src/pdtt_dp.sv -----
// ----------------------------------------------------------------------------
// pdtt_dp
// Datapath: registers, table, dividers, products, clamp and result forming.
// ----------------------------------------------------------------------------
module pdtt_dp
    import pdtt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    input  t_cmd        i_cmd,
    input  t_op         i_op,
    input  logic [17:0] i_gap,
    input  logic [17:0] i_inc,
    input  logic [3:0]  i_idx,
    input  logic [23:0] i_edur,
    input  logic [31:0] i_ecnt,
    output t_sts        o_sts,
    output logic [3:0]  o_bucket,
    output logic [17:0] o_aim,
    output logic        o_fire,
    output logic [15:0] o_pulse_ms,
    output logic        o_status,
    output logic [23:0] o_rd_dur,
    output logic [31:0] o_rd_cnt
);

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

    logic [13:0] r_width;
    logic [16:0] r_frac;
    logic [15:0] r_gu, r_go;
    logic [23:0] r_floor, r_ceil;
    logic signed [17:0] r_rlo, r_rhi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= 14'd50;
            r_frac  <= 17'd52429;
            r_gu    <= 16'd256;
            r_go    <= 16'd256;
            r_floor <= 24'd2560;
            r_ceil  <= 24'd512000;
            r_rlo   <= -18'sd500;
            r_rhi   <= 18'sd1000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_WIDTH:    r_width <= i_cfg_data[13:0];
                REG_FRACTION: r_frac  <= i_cfg_data[16:0];
                REG_GAIN_UND: r_gu    <= i_cfg_data[15:0];
                REG_GAIN_OVR: r_go    <= i_cfg_data[15:0];
                REG_FLOOR:    r_floor <= i_cfg_data;
                REG_CEILING:  r_ceil  <= i_cfg_data;
                REG_REJ_LOW:  r_rlo   <= i_cfg_data[17:0];
                REG_REJ_HIGH: r_rhi   <= i_cfg_data[17:0];
                default: ;
            endcase
        end
    end

    logic [23:0] r_dur_mem [BUCKETS];
    logic [31:0] r_cnt_mem [BUCKETS];

    t_op                r_op;
    logic signed [17:0] r_inc;
    logic [3:0]         r_idx;
    logic [23:0]        r_edur;
    logic [31:0]        r_ecnt;
    logic               r_gap_pos;
    logic               r_rej;

    // bucket divide: (gap-1)/w, restoring, 17 quotient bits
    logic [16:0] r_q;
    logic [13:0] r_rem;
    logic [13:0] w_eff;
    logic [14:0] div_try;
    assign w_eff   = (r_width == 14'd0) ? 14'd1 : r_width;
    assign div_try = {r_rem, r_q[16]} - {1'b0, w_eff};

    // aim and error
    logic [BW-1:0]  r_b;
    logic [35:0]    r_aim;      // Q16 aim, up to 2^17*16*2^14
    logic [23:0]    r_dcur;
    logic [31:0]    r_ccur;
    logic           r_neg;
    logic [36:0]    r_mag;
    logic [15:0]    r_gsel;
    logic [52:0]    r_prod;     // gain * |err| + half divisor
    logic [24:0]    r_adj;

    logic [BW-1:0]  b_sel;
    always_comb begin
        if (!r_gap_pos) begin
            b_sel = '0;
        end else if (r_q >= 17'(BUCKETS)) begin
            b_sel = BW'(BUCKETS - 1);
        end else begin
            b_sel = r_q[BW-1:0];
        end
    end

    logic [30:0] fw;
    logic [BW:0] bp1;
    assign fw  = r_frac * w_eff;
    assign bp1 = {1'b0, b_sel} + 1'b1;

    logic signed [37:0] err;
    logic [36:0]        mag;
    assign err = $signed({2'b00, r_aim}) - ($signed({{20{r_inc[17]}}, r_inc}) <<< 16);
    assign mag = err[37] ? 37'(-err) : 37'(err);

    logic [30:0] r_fw;

    logic [34:0] adj_y;
    logic [60:0] adj_p;
    assign adj_y = r_prod[52:18];
    assign adj_p = 61'(adj_y[29:0]) * 61'(ADJ_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_op;
            r_inc     <= i_inc;
            r_idx     <= i_idx;
            r_edur    <= i_edur;
            r_ecnt    <= i_ecnt;
            r_gap_pos <= !i_gap[17] && (i_gap != 18'd0);
            r_q       <= i_gap[16:0] - 17'd1;
            r_rem     <= '0;
            r_rej     <= ($signed(i_inc) < r_rlo) || ($signed(i_inc) > r_rhi);
        end
        if (i_cmd.div_step) begin
            if (!div_try[14]) begin
                r_rem <= div_try[13:0];
                r_q   <= {r_q[15:0], 1'b1};
            end else begin
                r_rem <= {r_rem[12:0], r_q[16]};
                r_q   <= {r_q[15:0], 1'b0};
            end
            r_fw <= fw;
        end
        if (i_cmd.mul_aim) begin
            r_b    <= b_sel;
            r_aim  <= 36'(r_fw) * 36'(bp1);
            r_dcur <= r_dur_mem[b_sel];
            r_ccur <= r_cnt_mem[b_sel];
        end
        if (i_cmd.err_calc) begin
            r_neg  <= err[37];
            r_mag  <= mag;
            r_gsel <= (err[37] || err == '0) ? r_go : r_gu;
        end
        if (i_cmd.mul_gain) begin
            r_prod <= 53'(r_gsel) * 53'(r_mag) + 53'(ADJ_HALF);
        end
        if (i_cmd.adj_recip) begin
            r_adj <= (adj_y >= ADJ_SAT_Y) ? '1 : adj_p[59:35];
        end
    end

    logic signed [26:0] nd;
    logic [23:0]        nd_c;
    assign nd = r_neg ? $signed({3'd0, r_dcur}) - $signed({2'd0, r_adj})
                      : $signed({3'd0, r_dcur}) + $signed({2'd0, r_adj});
    always_comb begin
        if (nd < $signed({3'd0, r_floor})) begin
            nd_c = r_floor;
        end else begin
            nd_c = nd[23:0];
        end
        if (nd > $signed({3'd0, r_ceil}) || (nd < $signed({3'd0, r_floor}) &&
                r_floor > r_ceil)) begin
            nd_c = r_ceil;
        end
    end

    logic [18:0] aim_r;
    logic [17:0] aim_sat;
    assign aim_r   = 19'((r_aim + 36'd32768) >> 16);
    assign aim_sat = aim_r[18] ? 18'h3FFFF : aim_r[17:0];

    logic [16:0] ms;
    assign ms = 17'((25'(r_dcur) + 25'd128) >> 8);

    logic idx_ok;
    assign idx_ok = (32'(r_idx) < 32'(BUCKETS));

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_bucket   <= '0;
            o_aim      <= '0;
            o_fire     <= 1'b0;
            o_pulse_ms <= '0;
            o_status   <= 1'b0;
            o_rd_dur   <= '0;
            o_rd_cnt   <= '0;
            case (r_op)
                OP_DECIDE: begin
                    o_bucket <= 4'(r_b);
                    o_aim    <= aim_sat;
                    if (r_dcur >= r_floor && r_dcur <= r_ceil) begin
                        o_fire     <= 1'b1;
                        o_pulse_ms <= ms[16] ? 16'hFFFF : ms[15:0];
                    end
                end
                OP_RECORD: begin
                    if (r_rej) begin
                        o_status <= 1'b1;
                    end else begin
                        o_bucket       <= 4'(r_b);
                        o_aim          <= aim_sat;
                        r_dur_mem[r_b] <= nd_c;
                        r_cnt_mem[r_b] <= (r_ccur == 32'hFFFF_FFFF) ? r_ccur : r_ccur + 32'd1;
                    end
                end
                OP_WRITE: begin
                    o_bucket <= r_idx;
                    if (idx_ok) begin
                        r_dur_mem[r_idx[BW-1:0]] <= r_edur;
                        r_cnt_mem[r_idx[BW-1:0]] <= r_ecnt;
                    end
                end
                default: begin
                    o_bucket <= r_idx;
                    if (idx_ok) begin
                        o_rd_dur <= r_dur_mem[r_idx[BW-1:0]];
                        o_rd_cnt <= r_cnt_mem[r_idx[BW-1:0]];
                    end
                end
            endcase
        end
    end

    assign o_sts.rejected = r_rej;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives decide, record, write and read beats into the pulse duration tuning
// table under several register settings, with random idle gaps on both
// streams, and checks every result beat against a local table predictor.
// ----------------------------------------------------------------------------
module testbench
    import pdtt_pkg::*;
();

    localparam int NBKT = BUCKETS;
    localparam int WDOG_LIMIT = 4000;

    typedef struct {
        t_op                op;
        logic signed [17:0] gap;
        logic signed [17:0] inc;
        logic [3:0]         idx;
        logic [23:0]        dur;
        logic [31:0]        cnt;
    } t_item;

    typedef struct packed {
        logic [31:0] rcnt;
        logic [23:0] rdur;
        logic        status;
        logic [15:0] pms;
        logic        fire;
        logic [17:0] aim;
        logic [3:0]  bucket;
    } t_res;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_index = '0;
    logic [23:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [1:0]   s_axis_tuser = '0;
    logic [95:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [95:0]  m_axis_tdata;

    pulse_duration_tuning_table dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // model registers and tables
    logic [13:0]        m_width;
    logic [16:0]        m_frac;
    logic [15:0]        m_gund, m_govr;
    logic [23:0]        m_floor, m_ceil;
    logic signed [17:0] m_rlo, m_rhi;
    logic [23:0]        dur_tab [NBKT];
    logic [31:0]        cnt_tab [NBKT];

    t_item pending_beats[$];
    t_res  expected_results[$];
    int    errors = 0;
    bit    took_in = 0;
    int    in_gap = 0, out_gap = 0;
    bit    hold_sender = 0;
    int    wdog = 0;

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(0, 2);
        if (r < 95) return $urandom_range(3, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [3:0] bucket_of(logic signed [17:0] gap);
        longint w, q;
        w = (m_width == 0) ? 1 : m_width;
        if (gap <= 0) return 0;
        q = (longint'(gap) - 1) / w;
        if (q >= NBKT) q = NBKT - 1;
        return q[3:0];
    endfunction

    function automatic longint aim_q16(logic [3:0] b);
        longint w;
        w = (m_width == 0) ? 1 : m_width;
        return longint'(m_frac) * (longint'(b) + 1) * w;
    endfunction

    function automatic logic [17:0] aim_round(longint a);
        longint r;
        r = (a + 32768) >>> 16;
        return (r > 262143) ? 18'h3FFFF : r[17:0];
    endfunction

    function automatic t_res table_step(t_item it);
        t_res   r;
        logic [3:0] b;
        longint a, err, mag, g, adj, nd, ms;
        r = '0;
        case (it.op)
            OP_DECIDE: begin
                b = bucket_of(it.gap);
                r.bucket = b;
                r.aim = aim_round(aim_q16(b));
                if (dur_tab[b] >= m_floor && dur_tab[b] <= m_ceil) begin
                    ms = (longint'(dur_tab[b]) + 128) >>> 8;
                    r.fire = 1'b1;
                    r.pms = (ms > 65535) ? 16'hFFFF : ms[15:0];
                end
            end
            OP_RECORD: begin
                if (it.inc < m_rlo || it.inc > m_rhi) begin
                    r.status = 1'b1;
                end else begin
                    b = bucket_of(it.gap);
                    a = aim_q16(b);
                    err = a - longint'(it.inc) * 65536;
                    g = (err > 0) ? m_gund : m_govr;
                    mag = (err < 0) ? -err : err;
                    adj = (g * mag + 3276800) / 6553600;
                    nd = longint'(dur_tab[b]) + ((err < 0) ? -adj : adj);
                    if (nd < longint'(m_floor)) nd = m_floor;
                    if (nd > longint'(m_ceil)) nd = m_ceil;
                    dur_tab[b] = nd[23:0];
                    if (cnt_tab[b] != 32'hFFFFFFFF) cnt_tab[b] = cnt_tab[b] + 1;
                    r.bucket = b;
                    r.aim = aim_round(a);
                end
            end
            OP_WRITE: begin
                r.bucket = it.idx;
                dur_tab[it.idx] = it.dur;
                cnt_tab[it.idx] = it.cnt;
            end
            default: begin
                r.bucket = it.idx;
                r.rdur = dur_tab[it.idx];
                r.rcnt = cnt_tab[it.idx];
            end
        endcase
        return r;
    endfunction

    // driver
    always @(negedge i_clk) begin
        logic nv;
        t_item it;
        if (i_rst_n) begin
            nv = s_axis_tvalid;
            if (s_axis_tvalid && took_in) nv = 1'b0;
            if (!nv) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (pending_beats.size() > 0 && !hold_sender) begin
                    it = pending_beats.pop_front();
                    s_axis_tuser <= it.op;
                    s_axis_tdata <= {it.cnt, it.dur, it.idx, it.inc, it.gap};
                    nv = 1'b1;
                    in_gap = rand_gap();
                end
            end
            s_axis_tvalid <= nv;
            if (out_gap > 0) begin
                out_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) out_gap = rand_gap();
            end
        end
    end

    // monitor, predictor and watchdog
    always @(posedge i_clk) begin
        t_item it;
        t_res  got, exp_r;
        took_in = s_axis_tvalid && s_axis_tready && i_rst_n;
        if (took_in) begin
            it.op  = t_op'(s_axis_tuser);
            it.gap = s_axis_tdata[17:0];
            it.inc = s_axis_tdata[35:18];
            it.idx = s_axis_tdata[39:36];
            it.dur = s_axis_tdata[63:40];
            it.cnt = s_axis_tdata[95:64];
            expected_results.push_back(table_step(it));
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (expected_results.size() == 0) begin
                $error("unexpected result beat %h", m_axis_tdata);
                errors++;
            end else begin
                exp_r = expected_results.pop_front();
                if (got.bucket != exp_r.bucket) begin
                    $error("bucket exp %0d got %0d", exp_r.bucket, got.bucket); errors++;
                end
                if (got.aim != exp_r.aim) begin
                    $error("target_wt exp %0d got %0d", exp_r.aim, got.aim); errors++;
                end
                if (got.fire != exp_r.fire) begin
                    $error("fire exp %0d got %0d", exp_r.fire, got.fire); errors++;
                end
                if (got.pms != exp_r.pms) begin
                    $error("pulse_ms exp %0d got %0d", exp_r.pms, got.pms); errors++;
                end
                if (got.status != exp_r.status) begin
                    $error("status exp %0d got %0d", exp_r.status, got.status); errors++;
                end
                if (got.rdur != exp_r.rdur) begin
                    $error("read_duration exp %0d got %0d", exp_r.rdur, got.rdur); errors++;
                end
                if (got.rcnt != exp_r.rcnt) begin
                    $error("read_count exp %0d got %0d", exp_r.rcnt, got.rcnt); errors++;
                end
            end
        end
        if (took_in || (m_axis_tvalid && m_axis_tready) || !i_rst_n) wdog = 0;
        else wdog++;
        if (wdog >= WDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic cfg_write(logic [2:0] idx, int val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= 24'(val);
        case (idx)
            REG_WIDTH:    m_width = val[13:0];
            REG_FRACTION: m_frac  = val[16:0];
            REG_GAIN_UND: m_gund  = val[15:0];
            REG_GAIN_OVR: m_govr  = val[15:0];
            REG_FLOOR:    m_floor = val[23:0];
            REG_CEILING:  m_ceil  = val[23:0];
            REG_REJ_LOW:  m_rlo   = val[17:0];
            default:      m_rhi   = val[17:0];
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_all(int w, int f, int gu, int go, int fl, int ce, int lo, int hi);
        cfg_write(REG_WIDTH, w);
        cfg_write(REG_FRACTION, f);
        cfg_write(REG_GAIN_UND, gu);
        cfg_write(REG_GAIN_OVR, go);
        cfg_write(REG_FLOOR, fl);
        cfg_write(REG_CEILING, ce);
        cfg_write(REG_REJ_LOW, lo);
        cfg_write(REG_REJ_HIGH, hi);
    endtask

    task automatic queue_beat(t_op op, int gap, int inc, int idx, int dur, int cnt);
        t_item it;
        it.op = op; it.gap = 18'(gap); it.inc = 18'(inc);
        it.idx = 4'(idx); it.dur = 24'(dur); it.cnt = 32'(cnt);
        pending_beats.push_back(it);
    endtask

    task automatic wait_drained();
        while (pending_beats.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic random_beats(int n);
        int r, gap, inc, span;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            span = (m_width == 0 ? 1 : m_width) * 18;
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 200000) - 100000
                                              : $urandom_range(0, span) - 20;
            if ($urandom_range(0, 3) == 0) inc = $urandom_range(0, 200000) - 100000;
            else inc = $urandom_range(0, 1700) - 600;
            if (r < 35) queue_beat(OP_DECIDE, gap, inc, $urandom, $urandom, $urandom);
            else if (r < 75) queue_beat(OP_RECORD, gap, inc, $urandom, $urandom, $urandom);
            else if (r < 85) queue_beat(OP_WRITE, gap, inc, $urandom_range(0, 15),
                                        ($urandom_range(0, 1) ? $urandom_range(0, 600000)
                                                              : $urandom),
                                        ($urandom_range(0, 3) == 0 ? 32'hFFFFFFF0 : $urandom));
            else queue_beat(OP_READ, gap, inc, $urandom_range(0, 15), $urandom, $urandom);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        set_all(50, 52429, 256, 256, 2560, 512000, -500, 1000);
        // load every entry first so no unwritten entry is ever read
        for (int e = 0; e < NBKT; e++)
            queue_beat(OP_WRITE, 0, 0, e, (e == 0) ? 0 : (e == 1) ? 24'hFFFFFF :
                       (e == 2) ? 2560 : 256 * 40 * e, (e == 3) ? 32'hFFFFFFFF : e);
        queue_beat(OP_DECIDE, -100000, 0, 0, 0, 0);
        queue_beat(OP_DECIDE, 0, 0, 0, 0, 0);
        queue_beat(OP_DECIDE, 51, 0, 0, 0, 0);
        queue_beat(OP_DECIDE, 100000, 0, 0, 0, 0);
        queue_beat(OP_RECORD, 200, -501, 0, 0, 0);
        queue_beat(OP_RECORD, 200, 1001, 0, 0, 0);
        queue_beat(OP_RECORD, 200, -500, 0, 0, 0);
        queue_beat(OP_RECORD, 200, 1000, 0, 0, 0);
        queue_beat(OP_READ, 0, 0, 3, 0, 0);
        wait_drained();
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: ;
                1: set_all(0, 65536, 65535, 0, 0, 24'hFFFFFF, -100000, 100000);
                2: set_all(16383, 131071, 0, 65535, 24'hFFFFFF, 24'hFFFFFF, -131072, 131071);
                3: set_all(10000, 0, 1000, 1000, 600000, 1000, -1000, 500);
                4: set_all(1, 32768, 4000, 200, 100, 300000, 100, -100);
                5: set_all($urandom_range(1, 300), $urandom_range(0, 65536),
                           $urandom_range(0, 65535), $urandom_range(0, 65535),
                           $urandom_range(0, 5000), $urandom_range(100000, 900000),
                           -$urandom_range(0, 1000), $urandom_range(0, 2000));
                6: set_all(50, 52429, 256, 256, 2560, 512000, -500, 1000);
                default: set_all($urandom_range(1, 10000), $urandom_range(0, 131071),
                                 $urandom, $urandom, $urandom_range(0, 20000),
                                 $urandom, $urandom, $urandom);
            endcase
            random_beats(120);
            // hold the sender until the block has fully drained
            while (pending_beats.size() > 0) @(posedge i_clk);
            hold_sender = 1;
            random_beats(120);
            while (s_axis_tvalid || expected_results.size() > 0) @(posedge i_clk);
            hold_sender = 0;
            wait_drained();
        end
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// ----- pulse_duration_tuning_table.f -----
src/pdtt_pkg.sv
src/pdtt_ctrl.sv
src/pdtt_dp.sv
src/pulse_duration_tuning_table.sv
tb/testbench.sv
